>>> rtl/leased_priority_task_table_unit_assert.svh
// assertion macros for the leased priority task table checker
`ifndef LEASED_PRIORITY_TASK_TABLE_UNIT_ASSERT_SVH
`define LEASED_PRIORITY_TASK_TABLE_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define LPTT_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lptt port check failed");

// next-cycle implication under reset
`define LPTT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lptt port check failed");

`endif

>>> rtl/lptt_pkg.sv
// shared constants, codes and types of the leased priority task table
package lptt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int TIME_BITS   = 48;
    localparam int KEY_BITS    = 16;

    typedef enum logic [2:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_CLAIM   = 3'd1,
        CMD_RENEW   = 3'd2,
        CMD_ACK     = 3'd3,
        CMD_NACK    = 3'd4,
        CMD_INSPECT = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_MISSING    = 3'd1,
        STAT_CONFLICT   = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_NOT_HOLDER = 3'd4,
        STAT_BAD_LEASE  = 3'd5,
        STAT_NONE       = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_PENDING = 2'd0,
        PH_LEASED  = 2'd1,
        PH_DONE    = 2'd2,
        PH_DEAD    = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_EMIT,
        ACT_NEW,
        ACT_LEASE,
        ACT_RENEW,
        ACT_ACK,
        ACT_NACK
    } act_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SEND
    } state_t;

    // request and pass control seen by every cell
    typedef struct packed {
        logic                        pass2;
        logic                        dl_en;
        logic [KEY_BITS-1:0]         tkey;
        logic [7:0]                  tenant;
        logic [KEY_BITS-1:0]         dkey;
        logic [31:0]                 digest;
        logic signed [7:0]           rank;
        logic [TIME_BITS-1:0]        ready;
        logic [7:0]                  limit;
        logic [7:0]                  worker;
        logic [7:0]                  stamp;
        logic [TIME_BITS-1:0]        now;
        logic [TIME_BITS-1:0]        exp_new;
        act_t                        act;
        logic [IDX_W-1:0]            target;
    } bcast_t;

    // token that walks the row, one cell per cycle
    typedef struct packed {
        logic                        valid;
        logic [IDX_W-1:0]            pos;
        logic                        dd_found;
        logic                        dd_same;
        logic                        k_found;
        logic                        k_same;
        logic                        k_holds;
        logic                        k_live;
        logic [IDX_W-1:0]            k_idx;
        logic                        free_found;
        logic [IDX_W-1:0]            free_idx;
        logic                        best_found;
        logic [IDX_W-1:0]            best_idx;
        logic signed [7:0]           best_rank;
        logic [KEY_BITS-1:0]         best_key;
        logic [KEY_BITS-1:0]         r_key;
        logic [7:0]                  r_stamp;
        phase_t                      r_phase;
        logic [7:0]                  r_tries;
        logic [7:0]                  r_holder;
        logic [TIME_BITS-1:0]        r_expiry;
        logic [TIME_BITS-1:0]        r_ready;
        logic signed [7:0]           r_rank;
        logic [7:0]                  r_limit;
        logic [7:0]                  r_tenant;
    } tok_t;

endpackage

>>> rtl/lptt_req_if.sv
// command channel of the task table
interface lptt_req_if;
    logic                               valid;
    logic                               ready;
    logic [2:0]                         command;
    logic [lptt_pkg::KEY_BITS-1:0]      task_key;
    logic [7:0]                         tenant_key;
    logic [lptt_pkg::KEY_BITS-1:0]      dedup_key;
    logic [31:0]                        content_digest;
    logic signed [7:0]                  rank;
    logic [lptt_pkg::TIME_BITS-1:0]     ready_time;
    logic [7:0]                         attempt_limit;
    logic [7:0]                         worker_key;
    logic [7:0]                         lease_stamp;
    logic [lptt_pkg::TIME_BITS-1:0]     current_time;
    logic [31:0]                        lease_length;

    modport source (
        output valid, command, task_key, tenant_key, dedup_key, content_digest, rank,
               ready_time, attempt_limit, worker_key, lease_stamp, current_time,
               lease_length,
        input  ready
    );
    modport sink (
        input  valid, command, task_key, tenant_key, dedup_key, content_digest, rank,
               ready_time, attempt_limit, worker_key, lease_stamp, current_time,
               lease_length,
        output ready
    );
endinterface

>>> rtl/lptt_rsp_if.sv
// result channel of the task table
interface lptt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               accepted;
    logic [2:0]                         status_code;
    logic [lptt_pkg::KEY_BITS-1:0]      out_task_key;
    logic [7:0]                         out_stamp;
    logic [1:0]                         out_phase;
    logic [7:0]                         out_tries;
    logic [7:0]                         out_holder;
    logic [lptt_pkg::TIME_BITS-1:0]     out_expiry;
    logic [lptt_pkg::TIME_BITS-1:0]     out_ready_time;
    logic signed [7:0]                  out_rank;
    logic [7:0]                         out_attempt_limit;
    logic [7:0]                         out_tenant;

    modport source (
        output valid, accepted, status_code, out_task_key, out_stamp, out_phase,
               out_tries, out_holder, out_expiry, out_ready_time, out_rank,
               out_attempt_limit, out_tenant,
        input  ready
    );
    modport sink (
        input  valid, accepted, status_code, out_task_key, out_stamp, out_phase,
               out_tries, out_holder, out_expiry, out_ready_time, out_rank,
               out_attempt_limit, out_tenant,
        output ready
    );
endinterface

>>> rtl/lptt_cell.sv
// one table slot: holds a task and updates the passing token
module lptt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  lptt_pkg::bcast_t bc,
    input  lptt_pkg::tok_t   tok_in,
    output lptt_pkg::tok_t   tok_out
);

    logic                              used_reg, used_next;
    logic [lptt_pkg::KEY_BITS-1:0]     key_reg, key_next;
    logic [7:0]                        tenant_reg, tenant_next;
    logic [lptt_pkg::KEY_BITS-1:0]     dkey_reg, dkey_next;
    logic [31:0]                       digest_reg, digest_next;
    logic signed [7:0]                 rank_reg, rank_next;
    logic [lptt_pkg::TIME_BITS-1:0]    ready_reg, ready_next;
    logic [7:0]                        limit_reg, limit_next;
    logic [7:0]                        tries_reg, tries_next;
    lptt_pkg::phase_t                  phase_reg, phase_next;
    logic [7:0]                        holder_reg, holder_next;
    logic [7:0]                        stamp_reg, stamp_next;
    logic [lptt_pkg::TIME_BITS-1:0]    expiry_reg, expiry_next;
    lptt_pkg::tok_t                    tok_reg, tok_next;

    // slot update and token accumulation
    always_comb
    begin
        logic same;
        logic open;
        logic better;
        used_next   = used_reg;
        key_next    = key_reg;
        tenant_next = tenant_reg;
        dkey_next   = dkey_reg;
        digest_next = digest_reg;
        rank_next   = rank_reg;
        ready_next  = ready_reg;
        limit_next  = limit_reg;
        tries_next  = tries_reg;
        phase_next  = phase_reg;
        holder_next = holder_reg;
        stamp_next  = stamp_reg;
        expiry_next = expiry_reg;
        tok_next     = tok_in;
        tok_next.pos = lptt_pkg::IDX_W'(tok_in.pos + 1'b1);

        same = key_reg == bc.tkey && tenant_reg == bc.tenant && dkey_reg == bc.dkey &&
               digest_reg == bc.digest && rank_reg == bc.rank && ready_reg == bc.ready &&
               limit_reg == bc.limit;
        open = (phase_reg == lptt_pkg::PH_PENDING || phase_reg == lptt_pkg::PH_LEASED) &&
               ready_reg <= bc.now &&
               !(phase_reg == lptt_pkg::PH_LEASED && expiry_reg > bc.now);
        better = !tok_in.best_found || rank_reg > tok_in.best_rank ||
                 (rank_reg == tok_in.best_rank && key_reg < tok_in.best_key);

        if (tok_in.valid && !bc.pass2)
        begin
            // first dedup match within the tenant
            if (used_reg && tenant_reg == bc.tenant && dkey_reg == bc.dkey && !tok_in.dd_found)
            begin
                tok_next.dd_found = 1'b1;
                tok_next.dd_same  = same;
            end
            // task key lookup
            if (used_reg && bc.tkey != '0 && key_reg == bc.tkey && !tok_in.k_found)
            begin
                tok_next.k_found = 1'b1;
                tok_next.k_same  = same;
                tok_next.k_idx   = tok_in.pos;
                tok_next.k_holds = phase_reg == lptt_pkg::PH_LEASED &&
                                   holder_reg == bc.worker && stamp_reg == bc.stamp;
                tok_next.k_live  = expiry_reg > bc.now;
            end
            // first free slot
            if (!used_reg && !tok_in.free_found)
            begin
                tok_next.free_found = 1'b1;
                tok_next.free_idx   = tok_in.pos;
            end
            // claim scan: dead-letter spent tasks, track the best one
            if (bc.dl_en && used_reg && tenant_reg == bc.tenant && open)
            begin
                if (tries_reg >= limit_reg)
                begin
                    phase_next  = lptt_pkg::PH_DEAD;
                    holder_next = '0;
                    expiry_next = '0;
                end
                else if (better)
                begin
                    tok_next.best_found = 1'b1;
                    tok_next.best_idx   = tok_in.pos;
                    tok_next.best_rank  = rank_reg;
                    tok_next.best_key   = key_reg;
                end
            end
        end

        if (tok_in.valid && bc.pass2 && tok_in.pos == bc.target)
        begin
            case (bc.act)
                lptt_pkg::ACT_NEW:
                begin
                    used_next   = 1'b1;
                    key_next    = bc.tkey;
                    tenant_next = bc.tenant;
                    dkey_next   = bc.dkey;
                    digest_next = bc.digest;
                    rank_next   = bc.rank;
                    ready_next  = bc.ready;
                    limit_next  = bc.limit;
                    tries_next  = '0;
                    phase_next  = lptt_pkg::PH_PENDING;
                    holder_next = '0;
                    stamp_next  = '0;
                    expiry_next = '0;
                end
                lptt_pkg::ACT_LEASE:
                begin
                    phase_next  = lptt_pkg::PH_LEASED;
                    holder_next = bc.worker;
                    stamp_next  = stamp_reg + 8'd1;
                    tries_next  = tries_reg + 8'd1;
                    expiry_next = bc.exp_new;
                end
                lptt_pkg::ACT_RENEW:
                begin
                    expiry_next = bc.exp_new;
                end
                lptt_pkg::ACT_ACK:
                begin
                    phase_next  = lptt_pkg::PH_DONE;
                    holder_next = '0;
                end
                lptt_pkg::ACT_NACK:
                begin
                    phase_next  = (tries_reg >= limit_reg) ? lptt_pkg::PH_DEAD
                                                           : lptt_pkg::PH_PENDING;
                    holder_next = '0;
                    expiry_next = '0;
                    ready_next  = bc.ready;
                end
                default:
                begin
                end
            endcase
            // report the task after its update
            tok_next.r_key    = key_next;
            tok_next.r_stamp  = stamp_next;
            tok_next.r_phase  = phase_next;
            tok_next.r_tries  = tries_next;
            tok_next.r_holder = holder_next;
            tok_next.r_expiry = expiry_next;
            tok_next.r_ready  = ready_next;
            tok_next.r_rank   = rank_next;
            tok_next.r_limit  = limit_next;
            tok_next.r_tenant = tenant_next;
        end
    end

    // occupancy and token hop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    // slot contents
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        tenant_reg <= tenant_next;
        dkey_reg   <= dkey_next;
        digest_reg <= digest_next;
        rank_reg   <= rank_next;
        ready_reg  <= ready_next;
        limit_reg  <= limit_next;
        tries_reg  <= tries_next;
        phase_reg  <= phase_next;
        holder_reg <= holder_next;
        stamp_reg  <= stamp_next;
        expiry_reg <= expiry_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/leased_priority_task_table_unit.sv
// Leased priority task table: a row of 64 slot cells that a token walks one cell per cycle.
// Every command takes two walks of the row, a scan that gathers matches, the free slot and the
// best claimable task (and dead-letters spent tasks on a claim) and an update walk that changes
// the chosen slot and picks up its fields, after which the result beat is offered. One command
// is in flight at a time; a new command beat is taken in the cycle after the result beat has
// been taken. No clearing is needed after reset: slots start empty.
module leased_priority_task_table_unit (
    input  logic         clk,
    input  logic         rst_n,
    lptt_req_if.sink     req,
    lptt_rsp_if.source   rsp
);

    localparam int N = lptt_pkg::TABLE_DEPTH;
    localparam int TB = lptt_pkg::TIME_BITS;

    lptt_pkg::state_t                  state_reg, state_next;
    logic                              launch_reg, launch_next;
    logic [2:0]                        cmd_reg;
    logic [lptt_pkg::KEY_BITS-1:0]     tkey_reg;
    logic [7:0]                        tenant_reg;
    logic [lptt_pkg::KEY_BITS-1:0]     dkey_reg;
    logic [31:0]                       digest_reg;
    logic signed [7:0]                 rank_reg;
    logic [TB-1:0]                     ready_reg;
    logic [7:0]                        limit_reg;
    logic [7:0]                        worker_reg;
    logic [7:0]                        stamp_reg;
    logic [TB-1:0]                     now_reg;
    logic [31:0]                       len_reg;

    lptt_pkg::act_t                    act_reg, act_next;
    logic [lptt_pkg::IDX_W-1:0]        target_reg, target_next;
    logic                              emit_reg, emit_next;
    lptt_pkg::status_t                 status_reg, status_next;

    lptt_pkg::tok_t                    res_reg;
    lptt_pkg::tok_t                    tok [N+1];
    lptt_pkg::tok_t                    tk;
    lptt_pkg::bcast_t                  bc;
    logic [TB:0]                       lease_sum;
    logic                              lease_ok;
    logic                              claim_ok;
    logic                              req_fire;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = state_reg == lptt_pkg::S_IDLE;

    // lease end and its range check
    assign lease_sum = (TB + 1)'(now_reg) + (TB + 1)'(len_reg);
    assign lease_ok  = len_reg != '0 && !lease_sum[TB];
    assign claim_ok  = worker_reg != '0 && tenant_reg != '0 && lease_ok;

    // request broadcast to the row
    always_comb
    begin
        bc.pass2   = state_reg == lptt_pkg::S_APPLY;
        bc.dl_en   = state_reg == lptt_pkg::S_SCAN &&
                     lptt_pkg::cmd_t'(cmd_reg) == lptt_pkg::CMD_CLAIM && claim_ok;
        bc.tkey    = tkey_reg;
        bc.tenant  = tenant_reg;
        bc.dkey    = dkey_reg;
        bc.digest  = digest_reg;
        bc.rank    = rank_reg;
        bc.ready   = ready_reg;
        bc.limit   = limit_reg;
        bc.worker  = worker_reg;
        bc.stamp   = stamp_reg;
        bc.now     = now_reg;
        bc.exp_new = lease_sum[TB-1:0];
        bc.act     = act_reg;
        bc.target  = target_reg;
    end

    // fresh token entering the first cell
    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = launch_reg;
    end

    // row of slot cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        lptt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bc      (bc),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign tk = tok[N];

    // decision after the scan, sequencing of the two walks
    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        act_next    = act_reg;
        target_next = target_reg;
        emit_next   = emit_reg;
        status_next = status_reg;
        case (state_reg)
            lptt_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next  = lptt_pkg::S_SCAN;
                    launch_next = 1'b1;
                end
            end
            lptt_pkg::S_SCAN:
            begin
                if (tk.valid)
                begin
                    state_next  = lptt_pkg::S_APPLY;
                    launch_next = 1'b1;
                    act_next    = lptt_pkg::ACT_NONE;
                    target_next = '0;
                    emit_next   = 1'b0;
                    status_next = lptt_pkg::STAT_MISSING;
                    case (lptt_pkg::cmd_t'(cmd_reg))
                        lptt_pkg::CMD_ENQUEUE:
                        begin
                            if (tkey_reg == '0 || tenant_reg == '0 || dkey_reg == '0 ||
                                digest_reg == '0 || limit_reg == '0)
                                status_next = lptt_pkg::STAT_MISSING;
                            else if (tk.dd_found)
                                status_next = tk.dd_same ? lptt_pkg::STAT_OK
                                                         : lptt_pkg::STAT_CONFLICT;
                            else if (tk.k_found)
                                status_next = tk.k_same ? lptt_pkg::STAT_OK
                                                        : lptt_pkg::STAT_CONFLICT;
                            else if (tk.free_found)
                            begin
                                status_next = lptt_pkg::STAT_OK;
                                act_next    = lptt_pkg::ACT_NEW;
                                target_next = tk.free_idx;
                            end
                            else
                                status_next = lptt_pkg::STAT_FULL;
                        end
                        lptt_pkg::CMD_CLAIM:
                        begin
                            if (worker_reg == '0 || tenant_reg == '0)
                                status_next = lptt_pkg::STAT_MISSING;
                            else if (!lease_ok)
                                status_next = lptt_pkg::STAT_BAD_LEASE;
                            else if (tk.best_found)
                            begin
                                status_next = lptt_pkg::STAT_OK;
                                act_next    = lptt_pkg::ACT_LEASE;
                                target_next = tk.best_idx;
                                emit_next   = 1'b1;
                            end
                            else
                                status_next = lptt_pkg::STAT_NONE;
                        end
                        lptt_pkg::CMD_RENEW, lptt_pkg::CMD_ACK, lptt_pkg::CMD_NACK,
                        lptt_pkg::CMD_INSPECT:
                        begin
                            if (tk.k_found)
                            begin
                                emit_next   = 1'b1;
                                target_next = tk.k_idx;
                                act_next    = lptt_pkg::ACT_EMIT;
                                if (lptt_pkg::cmd_t'(cmd_reg) == lptt_pkg::CMD_INSPECT)
                                    status_next = lptt_pkg::STAT_OK;
                                else if (!tk.k_holds)
                                    status_next = lptt_pkg::STAT_NOT_HOLDER;
                                else if (lptt_pkg::cmd_t'(cmd_reg) == lptt_pkg::CMD_RENEW)
                                begin
                                    if (!tk.k_live || !lease_ok)
                                        status_next = lptt_pkg::STAT_BAD_LEASE;
                                    else
                                    begin
                                        status_next = lptt_pkg::STAT_OK;
                                        act_next    = lptt_pkg::ACT_RENEW;
                                    end
                                end
                                else if (lptt_pkg::cmd_t'(cmd_reg) == lptt_pkg::CMD_ACK)
                                begin
                                    status_next = lptt_pkg::STAT_OK;
                                    act_next    = lptt_pkg::ACT_ACK;
                                end
                                else
                                begin
                                    status_next = lptt_pkg::STAT_OK;
                                    act_next    = lptt_pkg::ACT_NACK;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = lptt_pkg::STAT_MISSING;
                        end
                    endcase
                end
            end
            lptt_pkg::S_APPLY:
            begin
                if (tk.valid)
                    state_next = lptt_pkg::S_SEND;
            end
            lptt_pkg::S_SEND:
            begin
                if (rsp.ready)
                    state_next = lptt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lptt_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lptt_pkg::S_IDLE;
            launch_reg <= 1'b0;
            act_reg    <= lptt_pkg::ACT_NONE;
            target_reg <= '0;
            emit_reg   <= 1'b0;
            status_reg <= lptt_pkg::STAT_MISSING;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            act_reg    <= act_next;
            target_reg <= target_next;
            emit_reg   <= emit_next;
            status_reg <= status_next;
        end
    end

    // command capture and result capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg    <= req.command;
            tkey_reg   <= req.task_key;
            tenant_reg <= req.tenant_key;
            dkey_reg   <= req.dedup_key;
            digest_reg <= req.content_digest;
            rank_reg   <= req.rank;
            ready_reg  <= req.ready_time;
            limit_reg  <= req.attempt_limit;
            worker_reg <= req.worker_key;
            stamp_reg  <= req.lease_stamp;
            now_reg    <= req.current_time;
            len_reg    <= req.lease_length;
        end
        if (state_reg == lptt_pkg::S_APPLY && tk.valid)
            res_reg <= emit_reg ? tk : '0;
    end

    // result beat
    assign rsp.valid             = state_reg == lptt_pkg::S_SEND;
    assign rsp.accepted          = status_reg == lptt_pkg::STAT_OK;
    assign rsp.status_code       = status_reg;
    assign rsp.out_task_key      = res_reg.r_key;
    assign rsp.out_stamp         = res_reg.r_stamp;
    assign rsp.out_phase         = res_reg.r_phase;
    assign rsp.out_tries         = res_reg.r_tries;
    assign rsp.out_holder        = res_reg.r_holder;
    assign rsp.out_expiry        = res_reg.r_expiry;
    assign rsp.out_ready_time    = res_reg.r_ready;
    assign rsp.out_rank          = res_reg.r_rank;
    assign rsp.out_attempt_limit = res_reg.r_limit;
    assign rsp.out_tenant        = res_reg.r_tenant;

endmodule

>>> rtl/lptt_checker.sv
// port checker of the task table and its bind
`include "leased_priority_task_table_unit_assert.svh"

module lptt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       accepted,
    input logic [2:0] status_code
);

    // a result beat is ok exactly when it is accepted
    `LPTT_ASSERT_NOW(a_ok_flag, clk, rst_n, rsp_valid, accepted == (status_code == lptt_pkg::STAT_OK))
    // no status code past none
    `LPTT_ASSERT_NOW(a_status_range, clk, rst_n, rsp_valid, status_code <= lptt_pkg::STAT_NONE)
    // one command at a time
    `LPTT_ASSERT_NOW(a_one_at_a_time, clk, rst_n, rsp_valid, !req_ready)
    // a command beat never yields its result in the next cycle
    `LPTT_ASSERT_NEXT(a_not_instant, clk, rst_n, req_valid && req_ready, !rsp_valid)
    // a stalled result beat stays
    `LPTT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind leased_priority_task_table_unit lptt_checker u_lptt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .accepted    (rsp.accepted),
    .status_code (rsp.status_code)
);

>>> tb/leased_priority_task_table_unit_test.sv
// testbench for the leased priority task table: directed and random commands against a predictor
`timescale 1ns / 1ps

module leased_priority_task_table_unit_test;

    localparam logic [lptt_pkg::TIME_BITS-1:0] TIME_MAX = {lptt_pkg::TIME_BITS{1'b1}};

    typedef struct {
        logic [2:0]                     command;
        logic [lptt_pkg::KEY_BITS-1:0]  task_key;
        logic [7:0]                     tenant_key;
        logic [lptt_pkg::KEY_BITS-1:0]  dedup_key;
        logic [31:0]                    content_digest;
        logic signed [7:0]              rank;
        logic [lptt_pkg::TIME_BITS-1:0] ready_time;
        logic [7:0]                     attempt_limit;
        logic [7:0]                     worker_key;
        logic [7:0]                     lease_stamp;
        logic [lptt_pkg::TIME_BITS-1:0] current_time;
        logic [31:0]                    lease_length;
    } cmd_beat_t;

    typedef struct {
        logic                           accepted;
        logic [2:0]                     status_code;
        logic [lptt_pkg::KEY_BITS-1:0]  task_key;
        logic [7:0]                     stamp;
        logic [1:0]                     phase;
        logic [7:0]                     tries;
        logic [7:0]                     holder;
        logic [lptt_pkg::TIME_BITS-1:0] expiry;
        logic [lptt_pkg::TIME_BITS-1:0] ready_time;
        logic signed [7:0]              rank;
        logic [7:0]                     attempt_limit;
        logic [7:0]                     tenant;
    } outcome_t;

    typedef struct {
        bit                             used;
        logic [lptt_pkg::KEY_BITS-1:0]  task_key;
        logic [7:0]                     tenant;
        logic [lptt_pkg::KEY_BITS-1:0]  dedup_key;
        logic [31:0]                    digest;
        logic signed [7:0]              rank;
        logic [lptt_pkg::TIME_BITS-1:0] ready_time;
        logic [7:0]                     attempt_limit;
        logic [7:0]                     tries;
        lptt_pkg::phase_t               phase;
        logic [7:0]                     holder;
        logic [7:0]                     stamp;
        logic [lptt_pkg::TIME_BITS-1:0] expiry;
    } task_slot_t;

    logic clk;
    logic rst_n;
    lptt_req_if req ();
    lptt_rsp_if rsp ();

    task_slot_t table_model [lptt_pkg::TABLE_DEPTH];
    outcome_t   pending_outcomes [$];
    int         error_count;
    bit         no_idle;
    logic [lptt_pkg::TIME_BITS-1:0] clock_now;

    leased_priority_task_table_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // lease fits in the time range
    function automatic bit lease_fits(logic [lptt_pkg::TIME_BITS-1:0] now, logic [31:0] len);
        return len != 0 && {16'd0, len} <= {16'd0, TIME_MAX - now};
    endfunction

    function automatic int slot_of_key(logic [lptt_pkg::KEY_BITS-1:0] key);
        if (key == 0)
            return -1;
        for (int i = 0; i < lptt_pkg::TABLE_DEPTH; i++)
            if (table_model[i].used && table_model[i].task_key == key)
                return i;
        return -1;
    endfunction

    // apply one command to the table copy and return its result
    function automatic outcome_t apply_command(cmd_beat_t c);
        outcome_t          r;
        lptt_pkg::status_t st;
        int                hit;
        int                cand;
        int                free_idx;
        int                best;
        bit                same;
        r = '{default: '0};
        st = lptt_pkg::STAT_MISSING;
        hit = -1;
        cand = -1;
        free_idx = -1;
        best = -1;
        case (c.command)
            lptt_pkg::CMD_ENQUEUE:
            begin
                if (c.task_key != 0 && c.tenant_key != 0 && c.dedup_key != 0 &&
                    c.content_digest != 0 && c.attempt_limit != 0)
                begin
                    for (int i = 0; i < lptt_pkg::TABLE_DEPTH && cand < 0; i++)
                        if (table_model[i].used && table_model[i].tenant == c.tenant_key &&
                            table_model[i].dedup_key == c.dedup_key)
                            cand = i;
                    if (cand < 0)
                        cand = slot_of_key(c.task_key);
                    if (cand >= 0)
                    begin
                        same = table_model[cand].task_key == c.task_key &&
                               table_model[cand].tenant == c.tenant_key &&
                               table_model[cand].dedup_key == c.dedup_key &&
                               table_model[cand].digest == c.content_digest &&
                               table_model[cand].rank == c.rank &&
                               table_model[cand].ready_time == c.ready_time &&
                               table_model[cand].attempt_limit == c.attempt_limit;
                        st = same ? lptt_pkg::STAT_OK : lptt_pkg::STAT_CONFLICT;
                    end
                    else
                    begin
                        for (int i = 0; i < lptt_pkg::TABLE_DEPTH && free_idx < 0; i++)
                            if (!table_model[i].used)
                                free_idx = i;
                        if (free_idx < 0)
                            st = lptt_pkg::STAT_FULL;
                        else
                        begin
                            table_model[free_idx] = '{used: 1'b1, task_key: c.task_key,
                                tenant: c.tenant_key, dedup_key: c.dedup_key,
                                digest: c.content_digest, rank: c.rank,
                                ready_time: c.ready_time, attempt_limit: c.attempt_limit,
                                tries: 8'd0, phase: lptt_pkg::PH_PENDING, holder: 8'd0,
                                stamp: 8'd0, expiry: '0};
                            st = lptt_pkg::STAT_OK;
                        end
                    end
                end
            end
            lptt_pkg::CMD_CLAIM:
            begin
                if (c.worker_key == 0 || c.tenant_key == 0)
                    st = lptt_pkg::STAT_MISSING;
                else if (!lease_fits(c.current_time, c.lease_length))
                    st = lptt_pkg::STAT_BAD_LEASE;
                else
                begin
                    // dead-letter spent tasks, pick highest rank then lowest key
                    for (int i = 0; i < lptt_pkg::TABLE_DEPTH; i++)
                    begin
                        if (!table_model[i].used || table_model[i].tenant != c.tenant_key)
                            continue;
                        if (table_model[i].phase == lptt_pkg::PH_DONE ||
                            table_model[i].phase == lptt_pkg::PH_DEAD)
                            continue;
                        if (table_model[i].ready_time > c.current_time)
                            continue;
                        if (table_model[i].phase == lptt_pkg::PH_LEASED &&
                            table_model[i].expiry > c.current_time)
                            continue;
                        if (table_model[i].tries >= table_model[i].attempt_limit)
                        begin
                            table_model[i].phase = lptt_pkg::PH_DEAD;
                            table_model[i].holder = 8'd0;
                            table_model[i].expiry = '0;
                            continue;
                        end
                        if (best < 0 || table_model[i].rank > table_model[best].rank ||
                            (table_model[i].rank == table_model[best].rank &&
                             table_model[i].task_key < table_model[best].task_key))
                            best = i;
                    end
                    if (best < 0)
                        st = lptt_pkg::STAT_NONE;
                    else
                    begin
                        table_model[best].phase = lptt_pkg::PH_LEASED;
                        table_model[best].holder = c.worker_key;
                        table_model[best].stamp = table_model[best].stamp + 8'd1;
                        table_model[best].tries = table_model[best].tries + 8'd1;
                        table_model[best].expiry = c.current_time + c.lease_length;
                        hit = best;
                        st = lptt_pkg::STAT_OK;
                    end
                end
            end
            lptt_pkg::CMD_RENEW, lptt_pkg::CMD_ACK, lptt_pkg::CMD_NACK,
            lptt_pkg::CMD_INSPECT:
            begin
                hit = slot_of_key(c.task_key);
                if (hit < 0)
                    st = lptt_pkg::STAT_MISSING;
                else if (c.command == lptt_pkg::CMD_INSPECT)
                    st = lptt_pkg::STAT_OK;
                else if (table_model[hit].phase != lptt_pkg::PH_LEASED ||
                         table_model[hit].holder != c.worker_key ||
                         table_model[hit].stamp != c.lease_stamp)
                    st = lptt_pkg::STAT_NOT_HOLDER;
                else if (c.command == lptt_pkg::CMD_RENEW)
                begin
                    if (table_model[hit].expiry <= c.current_time ||
                        !lease_fits(c.current_time, c.lease_length))
                        st = lptt_pkg::STAT_BAD_LEASE;
                    else
                    begin
                        table_model[hit].expiry = c.current_time + c.lease_length;
                        st = lptt_pkg::STAT_OK;
                    end
                end
                else if (c.command == lptt_pkg::CMD_ACK)
                begin
                    table_model[hit].phase = lptt_pkg::PH_DONE;
                    table_model[hit].holder = 8'd0;
                    st = lptt_pkg::STAT_OK;
                end
                else
                begin
                    table_model[hit].phase =
                        table_model[hit].tries >= table_model[hit].attempt_limit ?
                        lptt_pkg::PH_DEAD : lptt_pkg::PH_PENDING;
                    table_model[hit].holder = 8'd0;
                    table_model[hit].expiry = '0;
                    table_model[hit].ready_time = c.ready_time;
                    st = lptt_pkg::STAT_OK;
                end
            end
            default:
                st = lptt_pkg::STAT_MISSING;
        endcase
        r.accepted = st == lptt_pkg::STAT_OK;
        r.status_code = st;
        if (hit >= 0)
        begin
            r.task_key = table_model[hit].task_key;
            r.stamp = table_model[hit].stamp;
            r.phase = table_model[hit].phase;
            r.tries = table_model[hit].tries;
            r.holder = table_model[hit].holder;
            r.expiry = table_model[hit].expiry;
            r.ready_time = table_model[hit].ready_time;
            r.rank = table_model[hit].rank;
            r.attempt_limit = table_model[hit].attempt_limit;
            r.tenant = table_model[hit].tenant;
        end
        return r;
    endfunction

    // send one command beat, predicting its result at acceptance
    task automatic send_command(cmd_beat_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.command = c.command;
        req.task_key = c.task_key;
        req.tenant_key = c.tenant_key;
        req.dedup_key = c.dedup_key;
        req.content_digest = c.content_digest;
        req.rank = c.rank;
        req.ready_time = c.ready_time;
        req.attempt_limit = c.attempt_limit;
        req.worker_key = c.worker_key;
        req.lease_stamp = c.lease_stamp;
        req.current_time = c.current_time;
        req.lease_length = c.lease_length;
        req.valid = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        pending_outcomes = {pending_outcomes, apply_command(c)};
        @(negedge clk);
    endtask

    function automatic cmd_beat_t blank_command(logic [2:0] op);
        cmd_beat_t c;
        c = '{default: '0};
        c.command = op;
        return c;
    endfunction

    function automatic cmd_beat_t task_command(logic [2:0] op,
                                               logic [lptt_pkg::KEY_BITS-1:0] key,
                                               logic [7:0] worker, logic [7:0] stamp,
                                               logic [lptt_pkg::TIME_BITS-1:0] now,
                                               logic [31:0] len);
        cmd_beat_t c;
        c = blank_command(op);
        c.task_key = key;
        c.worker_key = worker;
        c.lease_stamp = stamp;
        c.current_time = now;
        c.lease_length = len;
        return c;
    endfunction

    function automatic cmd_beat_t enqueue_command(logic [lptt_pkg::KEY_BITS-1:0] key,
                                                  logic [7:0] tenant,
                                                  logic [lptt_pkg::KEY_BITS-1:0] dkey,
                                                  logic [31:0] dig,
                                                  logic signed [7:0] rank,
                                                  logic [lptt_pkg::TIME_BITS-1:0] ready,
                                                  logic [7:0] limit);
        cmd_beat_t c;
        c = blank_command(lptt_pkg::CMD_ENQUEUE);
        c.task_key = key;
        c.tenant_key = tenant;
        c.dedup_key = dkey;
        c.content_digest = dig;
        c.rank = rank;
        c.ready_time = ready;
        c.attempt_limit = limit;
        return c;
    endfunction

    function automatic cmd_beat_t claim_command(logic [7:0] tenant, logic [7:0] worker,
                                                logic [lptt_pkg::TIME_BITS-1:0] now,
                                                logic [31:0] len);
        cmd_beat_t c;
        c = blank_command(lptt_pkg::CMD_CLAIM);
        c.tenant_key = tenant;
        c.worker_key = worker;
        c.current_time = now;
        c.lease_length = len;
        return c;
    endfunction

    // edge cases: empty fields, replay, conflict, leases, holder checks, bad codes
    task automatic test_directed();
        cmd_beat_t c;
        send_command(enqueue_command(16'd0, 8'd1, 16'd1, 32'd1, 8'sd0, '0, 8'd1));
        send_command(enqueue_command(16'd1, 8'd1, 16'd1, 32'd0, 8'sd0, '0, 8'd0));
        send_command(enqueue_command(16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'sd127,
                                     '0, 8'hFF));
        // exact replay, then a digest mismatch on the same dedup key
        send_command(enqueue_command(16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'sd127,
                                     '0, 8'hFF));
        send_command(enqueue_command(16'h0002, 8'hFF, 16'hFFFF, 32'h1, 8'sd127, '0, 8'hFF));
        send_command(enqueue_command(16'h0003, 8'hFF, 16'h0003, 32'h5, -8'sd128, '0, 8'd1));
        send_command(enqueue_command(16'h0004, 8'hFF, 16'h0004, 32'h5, 8'sd127, TIME_MAX,
                                     8'd1));
        send_command(claim_command(8'hFF, 8'd0, '0, 32'd10));
        send_command(claim_command(8'hFF, 8'd7, '0, 32'd0));
        send_command(claim_command(8'hFF, 8'd7, TIME_MAX, 32'd1));
        send_command(claim_command(8'hFF, 8'hFF, '0, 32'hFFFF_FFFF));
        send_command(task_command(lptt_pkg::CMD_INSPECT, 16'hFFFF, 8'd0, 8'd0, '0, 32'd0));
        send_command(task_command(lptt_pkg::CMD_RENEW, 16'hFFFF, 8'hFF, 8'd2, '0, 32'd5));
        send_command(task_command(lptt_pkg::CMD_RENEW, 16'hFFFF, 8'hFF, 8'd1, '0,
                                  32'hFFFF_FFFF));
        send_command(task_command(lptt_pkg::CMD_RENEW, 16'hFFFF, 8'hFF, 8'd1,
                                  48'hFFFF_FFFF, 32'd1));
        send_command(task_command(lptt_pkg::CMD_ACK, 16'hFFFF, 8'hFF, 8'd1, '0, 32'd0));
        // single-try task: claim, nack to dead letter
        send_command(claim_command(8'hFF, 8'd9, 48'd10, 32'd20));
        c = task_command(lptt_pkg::CMD_NACK, 16'h0003, 8'd9, 8'd1, 48'd11, 32'd0);
        c.ready_time = TIME_MAX;
        send_command(c);
        send_command(task_command(lptt_pkg::CMD_INSPECT, 16'h0003, 8'd0, 8'd0, '0, 32'd0));
        send_command(claim_command(8'hFF, 8'd9, TIME_MAX - 48'd1, 32'd1));
        send_command(task_command(lptt_pkg::CMD_ACK, 16'h0000, 8'hFF, 8'hFF, '0, 32'd0));
        send_command(blank_command(3'd6));
        send_command(blank_command(3'd7));
    endtask

    // well-formed traffic: small tenant and key pools, correct holder most of the time
    function automatic cmd_beat_t lifecycle_command();
        cmd_beat_t c;
        int pick;
        int j;
        pick = $urandom_range(0, 99);
        clock_now = clock_now + 48'($urandom_range(0, 12));
        c = blank_command(lptt_pkg::CMD_ENQUEUE);
        if (pick < 28)
        begin
            j = $urandom_range(0, lptt_pkg::TABLE_DEPTH - 1);
            if (table_model[j].used && $urandom_range(0, 5) == 0)
                c = enqueue_command(table_model[j].task_key, table_model[j].tenant,
                                    table_model[j].dedup_key, table_model[j].digest,
                                    table_model[j].rank, table_model[j].ready_time,
                                    table_model[j].attempt_limit);
            else
                c = enqueue_command(16'($urandom_range(1, 400)), 8'($urandom_range(1, 4)),
                                    16'($urandom_range(1, 40)), 32'($urandom_range(1, 3)),
                                    8'($urandom_range(0, 255)),
                                    clock_now + 48'($urandom_range(0, 30)),
                                    8'($urandom_range(1, 3)));
        end
        else if (pick < 58)
            c = claim_command(8'($urandom_range(1, 4)), 8'($urandom_range(1, 5)), clock_now,
                              32'($urandom_range(1, 60)));
        else if (pick < 90)
        begin
            j = $urandom_range(0, lptt_pkg::TABLE_DEPTH - 1);
            c = task_command(3'(lptt_pkg::CMD_RENEW + $urandom_range(0, 2)),
                             table_model[j].task_key, table_model[j].holder,
                             table_model[j].stamp, clock_now, 32'($urandom_range(1, 60)));
            if (!table_model[j].used)
                c.task_key = 16'($urandom_range(1, 400));
            if ($urandom_range(0, 7) == 0)
                c.lease_stamp = c.lease_stamp + 8'd1;
            if ($urandom_range(0, 9) == 0)
                c.worker_key = 8'($urandom_range(1, 5));
            c.ready_time = clock_now + 48'($urandom_range(0, 30));
        end
        else
        begin
            j = $urandom_range(0, lptt_pkg::TABLE_DEPTH - 1);
            c = task_command(lptt_pkg::CMD_INSPECT, table_model[j].used ?
                             table_model[j].task_key : 16'($urandom_range(0, 400)),
                             8'd0, 8'd0, '0, 32'd0);
        end
        return c;
    endfunction

    task automatic test_lifecycle(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
                no_idle = $urandom_range(0, 2) == 0;
            send_command(lifecycle_command());
        end
        no_idle = 1'b0;
    endtask

    // fully random fields, undefined codes included
    task automatic test_noise(int count);
        cmd_beat_t c;
        for (int n = 0; n < count; n++)
        begin
            c.command = 3'($urandom);
            c.task_key = 16'($urandom);
            c.tenant_key = 8'($urandom);
            c.dedup_key = 16'($urandom);
            c.content_digest = $urandom;
            c.rank = 8'($urandom);
            c.ready_time = 48'({$urandom, $urandom});
            c.attempt_limit = 8'($urandom);
            c.worker_key = 8'($urandom);
            c.lease_stamp = 8'($urandom);
            c.current_time = 48'({$urandom, $urandom});
            c.lease_length = $urandom;
            send_command(c);
        end
    endtask

    // result side stalls
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready = 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            @(negedge clk);
        end
    end

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want)
        begin
            $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
            error_count++;
        end
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("unexpected result beat at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                report_mismatch("accepted", rsp.accepted, want.accepted);
                report_mismatch("status_code", rsp.status_code, want.status_code);
                report_mismatch("out_task_key", rsp.out_task_key, want.task_key);
                report_mismatch("out_stamp", rsp.out_stamp, want.stamp);
                report_mismatch("out_phase", rsp.out_phase, want.phase);
                report_mismatch("out_tries", rsp.out_tries, want.tries);
                report_mismatch("out_holder", rsp.out_holder, want.holder);
                report_mismatch("out_expiry", rsp.out_expiry, want.expiry);
                report_mismatch("out_ready_time", rsp.out_ready_time, want.ready_time);
                report_mismatch("out_rank", rsp.out_rank, want.rank);
                report_mismatch("out_attempt_limit", rsp.out_attempt_limit,
                                want.attempt_limit);
                report_mismatch("out_tenant", rsp.out_tenant, want.tenant);
            end
        end
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("leased_priority_task_table_unit test failed");
        $finish;
    end

    // main sequence
    initial
    begin
        for (int i = 0; i < lptt_pkg::TABLE_DEPTH; i++)
            table_model[i] = '{phase: lptt_pkg::PH_PENDING, default: '0};
        error_count = 0;
        no_idle = 1'b0;
        clock_now = '0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.command = '0;
        req.task_key = '0;
        req.tenant_key = '0;
        req.dedup_key = '0;
        req.content_digest = '0;
        req.rank = '0;
        req.ready_time = '0;
        req.attempt_limit = '0;
        req.worker_key = '0;
        req.lease_stamp = '0;
        req.current_time = '0;
        req.lease_length = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_lifecycle(1100);
        test_noise(130);
        req.valid = 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("leased_priority_task_table_unit test passed");
        else
            $display("leased_priority_task_table_unit test failed");
        $finish;
    end

endmodule

>>> leased_priority_task_table_unit.f
+incdir+rtl
rtl/lptt_pkg.sv
rtl/lptt_req_if.sv
rtl/lptt_rsp_if.sv
rtl/lptt_cell.sv
rtl/leased_priority_task_table_unit.sv
rtl/lptt_checker.sv
tb/leased_priority_task_table_unit_test.sv
